### hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

    // Field widths fixed by the port list.
    localparam int KIND_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int CELL_W    = 16;
    localparam int COLOR_W   = 8;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    // Character codes and cell defaults.
    localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd7;
    localparam int                 TAB_STEP    = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_FILL,
        ST_SCROLL,
        ST_BLANK
    } t_state;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_ROW1,
        PTR_LASTROW
    } t_ptr_sel;

    typedef struct packed {
        logic     accept;       // request taken this cycle
        logic     fill;         // write a blank at the sweep pointer
        logic     fill_reset;   // blank uses the reset color
        logic     copy;         // read one cell for the scroll copy
        logic     finish;       // load the result registers
        logic     res_read;     // result carries the read data
        logic     res_scrolled; // result flags a scroll
        t_ptr_sel ptr_sel;
    } t_cmd;

    typedef struct packed {
        logic put_scroll;   // current put would move below the last row
        logic ptr_at_last;  // sweep pointer on the last cell
        logic fill_last;    // last blank write happens this cycle
    } t_status;

endpackage

### hw/rtl/tcw_ctrl.sv
// Sequencing state machine for the text console writer.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   i_kind,
    input  t_status             i_status,
    output t_cmd                o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.ptr_sel = PTR_HOLD;
        busy    = 1'b1;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.fill       = 1'b1;
                o_cmd.fill_reset = 1'b1;
                if (i_status.fill_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.accept = 1'b1;
                    unique case (t_kind'(i_kind))
                        KIND_PUT: begin
                            if (i_status.put_scroll) begin
                                o_cmd.ptr_sel = PTR_ROW1;
                                n_state       = ST_SCROLL;
                            end else begin
                                o_cmd.finish = 1'b1;
                            end
                        end
                        KIND_READ: begin
                            n_state = ST_READ;
                        end
                        KIND_CLEAR: begin
                            o_cmd.ptr_sel = PTR_ZERO;
                            n_state       = ST_FILL;
                        end
                        KIND_NOP: begin
                            o_cmd.finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.finish   = 1'b1;
                o_cmd.res_read = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_SCROLL: begin
                o_cmd.copy = 1'b1;
                if (i_status.ptr_at_last) begin
                    o_cmd.ptr_sel = PTR_LASTROW;
                    n_state       = ST_BLANK;
                end
            end
            ST_BLANK: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_last) begin
                    o_cmd.finish       = 1'b1;
                    o_cmd.res_scrolled = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

endmodule

### hw/rtl/tcw_datapath.sv
// Screen store, cursor, sweep pointer and result registers of the text console writer.
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_text_color_we,
    input  logic [COLOR_W-1:0]    i_text_color,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [INDEX_W-1:0]    i_cell_index,
    output logic                  o_done,
    output logic [CELL_W-1:0]     o_cell_value,
    output logic [ROW_OUT_W-1:0]  o_cursor_row,
    output logic [COL_OUT_W-1:0]  o_cursor_col,
    output logic                  o_scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CLW   = $clog2(COLUMNS);
    localparam int CW    = $clog2(COLUMNS + TAB_STEP);
    localparam int XW    = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

    localparam logic [AW-1:0] LAST      = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] LASTROW_A = AW'((ROWS - 1) * COLUMNS);
    localparam logic [RW-1:0] ROW_MAX   = RW'(ROWS - 1);
    localparam logic [CW-1:0] COLS_C    = CW'(COLUMNS);
    localparam logic [CW-1:0] TAB_MASK  = ~CW'(TAB_STEP - 1);

    logic [CELL_W-1:0]  r_mem [CELLS];
    logic [CELL_W-1:0]  r_rdata;
    logic               r_rd_ok;
    logic [COLOR_W-1:0] r_color;
    logic [RW-1:0]      r_row;
    logic [RW-1:0]      n_row;
    logic [CLW-1:0]     r_col;
    logic [CLW-1:0]     n_col;
    logic [AW-1:0]      r_ptr;
    logic               r_wvalid;
    logic [AW-1:0]      r_waddr;
    logic               r_done;
    logic [CELL_W-1:0]  r_value;
    logic [ROW_OUT_W-1:0] r_row_o;
    logic [COL_OUT_W-1:0] r_col_o;
    logic               r_scrolled;

    logic               is_nl;
    logic               is_tab;
    logic [CW-1:0]      col_adv;
    logic               wrap;
    logic [RW-1:0]      p_row;
    logic [CLW-1:0]     p_col;
    logic               p_scroll;
    logic [AW-1:0]      put_addr;
    logic [XW-1:0]      idx_x;
    logic               idx_ok;
    logic [AW-1:0]      rd_addr;
    logic               fill_step;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [COLOR_W-1:0] blank_color;
    logic [RW+ROW_OUT_W-1:0]  row_ext;
    logic [CLW+COL_OUT_W-1:0] col_ext;

    // Cursor advance for a put.
    always_comb begin
        is_nl   = (i_char_code == CH_NEWLINE);
        is_tab  = (i_char_code == CH_TAB);
        if (is_tab) begin
            col_adv = (CW'(r_col) + CW'(TAB_STEP)) & TAB_MASK;
        end else begin
            col_adv = CW'(r_col) + CW'(1);
        end
        wrap     = is_nl || (col_adv >= COLS_C);
        p_scroll = wrap && (r_row == ROW_MAX);
        if (wrap) begin
            p_col = '0;
            p_row = p_scroll ? r_row : r_row + RW'(1);
        end else begin
            p_col = col_adv[CLW-1:0];
            p_row = r_row;
        end
        put_addr = AW'(r_row) * COLS_A + AW'(r_col);
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_cmd.accept) begin
            priority if (t_kind'(i_kind) == KIND_PUT) begin
                n_row = p_row;
                n_col = p_col;
            end else if (t_kind'(i_kind) == KIND_CLEAR) begin
                n_row = '0;
                n_col = '0;
            end
        end
    end

    assign idx_x   = XW'(i_cell_index);
    assign idx_ok  = (idx_x < XW'(CELLS));
    assign rd_addr = i_cmd.copy ? r_ptr : idx_x[AW-1:0];

    // One write port: drain a pending copy first, then blanks, then a put.
    assign fill_step   = i_cmd.fill && !r_wvalid;
    assign blank_color = i_cmd.fill_reset ? RESET_COLOR : r_color;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = {blank_color, CH_SPACE};
        priority if (r_wvalid) begin
            mem_we    = 1'b1;
            mem_waddr = r_waddr;
            mem_wdata = r_rdata;
        end else if (i_cmd.fill) begin
            mem_we = 1'b1;
        end else if (i_cmd.accept && (t_kind'(i_kind) == KIND_PUT) && !is_nl && !is_tab) begin
            mem_we    = 1'b1;
            mem_waddr = put_addr;
            mem_wdata = {r_color, i_char_code};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_ok <= idx_ok;
        end
        if (i_cmd.copy) begin
            r_waddr <= r_ptr - COLS_A;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color  <= RESET_COLOR;
            r_row    <= '0;
            r_col    <= '0;
            r_ptr    <= '0;
            r_wvalid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            if (i_text_color_we) begin
                r_color <= i_text_color;
            end
            r_row    <= n_row;
            r_col    <= n_col;
            r_wvalid <= i_cmd.copy;
            r_done   <= i_cmd.finish;
            unique case (i_cmd.ptr_sel)
                PTR_ZERO:    r_ptr <= '0;
                PTR_ROW1:    r_ptr <= COLS_A;
                PTR_LASTROW: r_ptr <= LASTROW_A;
                PTR_HOLD: begin
                    if ((fill_step || i_cmd.copy) && (r_ptr != LAST)) begin
                        r_ptr <= r_ptr + AW'(1);
                    end
                end
            endcase
        end
    end

    // Result fields: cursor masked to the port widths.
    assign row_ext = {{ROW_OUT_W{1'b0}}, n_row};
    assign col_ext = {{COL_OUT_W{1'b0}}, n_col};

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_value    <= (i_cmd.res_read && r_rd_ok) ? r_rdata : '0;
            r_row_o    <= row_ext[ROW_OUT_W-1:0];
            r_col_o    <= col_ext[COL_OUT_W-1:0];
            r_scrolled <= i_cmd.res_scrolled;
        end
    end

    assign o_status.put_scroll  = p_scroll;
    assign o_status.ptr_at_last = (r_ptr == LAST);
    assign o_status.fill_last   = (r_ptr == LAST) && !r_wvalid;

    assign o_done       = r_done;
    assign o_cell_value = r_value;
    assign o_cursor_row = r_row_o;
    assign o_cursor_col = r_col_o;
    assign o_scrolled   = r_scrolled;

endmodule

### hw/rtl/text_console_writer_unit.sv
// Top level of the text console writer: ROWS x COLUMNS text screen with cursor.
//
// Issue a request by raising start while busy is low; kind selects put (0),
// read (1), clear (2) or no operation (3). Every request yields exactly one
// result, shown on the o_ ports for a single cycle with o_done high; the
// receiver cannot stall it, so capture it in that cycle. A put that does not
// scroll and a no operation return their result the next cycle and busy stays
// low, so one may be issued every cycle; a read waits for the registered
// memory read with busy high; a clear sweeps every cell; a put that scrolls
// copies rows up one cell a cycle and then blanks the bottom row. After
// reset the block blanks the whole screen with busy high. Write
// i_text_color with i_text_color_we while no request is in flight; it sets
// the attribute of written and blanked cells. Cursor outputs are the cursor
// after the request, truncated to 5 and 7 bits.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [INDEX_W-1:0]    i_cell_index,
    input  logic                  i_text_color_we,
    input  logic [COLOR_W-1:0]    i_text_color,
    output logic                  o_done,
    output logic [CELL_W-1:0]     o_cell_value,
    output logic [ROW_OUT_W-1:0]  o_cursor_row,
    output logic [COL_OUT_W-1:0]  o_cursor_col,
    output logic                  o_scrolled
);

    t_cmd    cmd;
    t_status status;

    // Sequencer: decode the request, run the sweeps, fire the result.
    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_kind   (i_kind),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Screen memory, cursor and result registers.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_text_color_we (i_text_color_we),
        .i_text_color    (i_text_color),
        .i_kind          (i_kind),
        .i_char_code     (i_char_code),
        .i_cell_index    (i_cell_index),
        .o_done          (o_done),
        .o_cell_value    (o_cell_value),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_col    (o_cursor_col),
        .o_scrolled      (o_scrolled)
    );

    // A result follows either a request taken the cycle before or a busy phase.
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a request");

    // A scroll always leaves the cursor at the start of a line.
    a_scroll_home_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_scrolled) |-> (o_cursor_col == '0))
        else $error("scroll with cursor off column zero");

    // A scroll comes only at the end of the copy and blank sweeps.
    a_scroll_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_scrolled) |-> $past(busy))
        else $error("scroll result without a sweep");

    // Read data needs the registered memory cycle first.
    a_read_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_cell_value != '0)) |-> $past(busy))
        else $error("cell value without a read cycle");

endmodule

### dv/tb_text_console_writer_unit.sv
// Testbench for text_console_writer_unit: directed and random requests checked against a screen model.
module tb_text_console_writer_unit;
    import tcw_pkg::*;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    // Result of one request as the block should report it.
    typedef struct packed {
        logic [CELL_W-1:0]    cell_value;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic                 scrolled;
    } t_console_status;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 start           = 1'b0;
    logic                 busy;
    logic [KIND_W-1:0]    i_kind          = '0;
    logic [CHAR_W-1:0]    i_char_code     = '0;
    logic [INDEX_W-1:0]   i_cell_index    = '0;
    logic                 i_text_color_we = 1'b0;
    logic [COLOR_W-1:0]   i_text_color    = '0;
    logic                 o_done;
    logic [CELL_W-1:0]    o_cell_value;
    logic [ROW_OUT_W-1:0] o_cursor_row;
    logic [COL_OUT_W-1:0] o_cursor_col;
    logic                 o_scrolled;

    // Screen model: cells, cursor and the current attribute byte.
    logic [CELL_W-1:0]  screen_model [CELL_COUNT];
    int                 cur_row;
    int                 cur_col;
    logic [COLOR_W-1:0] model_color;

    // Expected status of every request taken but not yet answered, oldest first.
    t_console_status pending_status [$];
    int              mismatch_count = 0;
    int              requests_sent  = 0;
    bit              idle_on        = 1'b1;

    text_console_writer_unit #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_char_code    (i_char_code),
        .i_cell_index   (i_cell_index),
        .i_text_color_we(i_text_color_we),
        .i_text_color   (i_text_color),
        .o_done         (o_done),
        .o_cell_value   (o_cell_value),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_col   (o_cursor_col),
        .o_scrolled     (o_scrolled)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Screen model
    // ------------------------------------------------------------------

    // Fill every cell with a space in the given attribute.
    function automatic void blank_screen_model(logic [COLOR_W-1:0] attr);
        for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {attr, CH_SPACE};
    endfunction

    // Go to column 0 of the next row; below the last row, shift all rows up
    // one and blank the bottom row in the current color. Return 1 on a scroll.
    function automatic bit line_feed();
        cur_col = 0;
        cur_row++;
        if (cur_row < ROWS) return 1'b0;
        cur_row = ROWS - 1;
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
        for (int c = 0; c < COLUMNS; c++)
            screen_model[(ROWS - 1) * COLUMNS + c] = {model_color, CH_SPACE};
        return 1'b1;
    endfunction

    // Apply one request to the model and return the status the block owes for it.
    function automatic t_console_status apply_to_screen(t_kind kind, logic [CHAR_W-1:0] ch,
                                                        logic [INDEX_W-1:0] idx);
        t_console_status st;
        st = '0;
        case (kind)
            KIND_PUT: begin
                if (ch == CH_NEWLINE) begin
                    st.scrolled = line_feed();
                end else if (ch == CH_TAB) begin
                    // Tab: round up to the next tab stop, wrap once past the last column.
                    cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
                    if (cur_col >= COLUMNS) st.scrolled = line_feed();
                end else begin
                    screen_model[cur_row * COLUMNS + cur_col] = {model_color, ch};
                    cur_col++;
                    if (cur_col >= COLUMNS) st.scrolled = line_feed();
                end
            end
            KIND_READ: begin
                // Out-of-range index reads as zero.
                if (idx < CELL_COUNT) st.cell_value = screen_model[idx];
            end
            KIND_CLEAR: begin
                // Clear blanks in the current color, not the reset color.
                blank_screen_model(model_color);
                cur_row = 0;
                cur_col = 0;
            end
            default: ;
        endcase
        st.cursor_row = cur_row[ROW_OUT_W-1:0];
        st.cursor_col = cur_col[COL_OUT_W-1:0];
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every o_done cycle is compared with the oldest request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_console_status exp_st;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_status.size() == 0) begin
                $error("result with no request outstanding: cell %h row %0d col %0d scrolled %b",
                       o_cell_value, o_cursor_row, o_cursor_col, o_scrolled);
                mismatch_count++;
            end else begin
                exp_st = pending_status.pop_front();
                if (o_cell_value !== exp_st.cell_value) begin
                    $error("cell_value: expected %h, got %h", exp_st.cell_value, o_cell_value);
                    mismatch_count++;
                end
                if (o_cursor_row !== exp_st.cursor_row) begin
                    $error("cursor_row: expected %0d, got %0d", exp_st.cursor_row, o_cursor_row);
                    mismatch_count++;
                end
                if (o_cursor_col !== exp_st.cursor_col) begin
                    $error("cursor_col: expected %0d, got %0d", exp_st.cursor_col, o_cursor_col);
                    mismatch_count++;
                end
                if (o_scrolled !== exp_st.scrolled) begin
                    $error("scrolled: expected %b, got %b", exp_st.scrolled, o_scrolled);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Idle the sender for a random stretch: mostly none or short, a few long.
    task automatic sender_gap();
        int pick;
        int len;
        if (!idle_on) return;
        pick = $urandom_range(0, 9);
        if (pick < 5)      len = 0;
        else if (pick < 9) len = $urandom_range(1, 3);
        else               len = $urandom_range(8, 40);
        if (len > 0) begin
            start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    // Present one request and hold it until the block takes it; then log the
    // expected status. Leave start high when no gap follows so that back-to-back
    // requests stay back to back.
    task automatic issue_request(t_kind kind, logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] idx);
        start        <= 1'b1;
        i_kind       <= kind;
        i_char_code  <= ch;
        i_cell_index <= idx;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_status.push_back(apply_to_screen(kind, ch, idx));
        if (kind != KIND_NOP) requests_sent++;
        sender_gap();
    endtask

    // Drop start and hold until every request is answered and the block is idle.
    task automatic wait_until_quiet();
        if (start) start <= 1'b0;
        while (pending_status.size() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    // Write the attribute register; only legal while nothing is in flight.
    task automatic write_text_color(logic [COLOR_W-1:0] value);
        wait_until_quiet();
        i_text_color_we <= 1'b1;
        i_text_color    <= value;
        @(posedge i_clk);
        model_color = value;
        i_text_color_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Freshly reset screen: blank cell, out-of-range read, no operation.
    task automatic test_power_up();
        issue_request(KIND_READ, 8'h00, 11'd0);
        issue_request(KIND_READ, 8'h00, 11'd2000);
        issue_request(KIND_NOP, 8'hFF, 11'h7FF);
    endtask

    // Character extremes, tab and newline in the reset color.
    task automatic test_put_codes();
        issue_request(KIND_PUT, 8'h41, 11'd0);
        issue_request(KIND_PUT, 8'h00, 11'h7FF);
        issue_request(KIND_PUT, 8'hFF, 11'd0);
        issue_request(KIND_PUT, CH_TAB, 11'd0);
        issue_request(KIND_PUT, CH_NEWLINE, 11'd0);
        issue_request(KIND_READ, 8'h00, 11'd1);
    endtask

    // March tabs across a full row so the last one wraps to the next line.
    task automatic test_tab_wrap();
        for (int i = 0; i < COLUMNS / TAB_STEP; i++) issue_request(KIND_PUT, CH_TAB, 11'd0);
    endtask

    // Clear under a non-reset color, then read back the last cell.
    task automatic test_clear_color();
        write_text_color(8'hFF);
        issue_request(KIND_CLEAR, 8'h00, 11'd0);
        issue_request(KIND_READ, 8'h00, 11'(CELL_COUNT - 1));
    endtask

    // Random traffic built from short runs: text, newline bursts, tab runs,
    // reads near the cursor, noise, pauses and the odd clear.
    task automatic test_random_traffic(int n_requests);
        int goal;
        int sel;
        int len;
        logic [CHAR_W-1:0] ch;
        logic [INDEX_W-1:0] idx;
        goal = requests_sent + n_requests;
        while (requests_sent < goal) begin
            sel     = $urandom_range(0, 99);
            len     = $urandom_range(1, 12);
            idle_on = ($urandom_range(0, 3) != 0);
            if (sel < 35) begin
                // Text run; mostly printable, sometimes any byte.
                len = $urandom_range(1, 40);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 7) == 0) ch = CHAR_W'($urandom_range(0, 255));
                    else                           ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
                    issue_request(KIND_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
                end
            end else if (sel < 55) begin
                for (int i = 0; i < len; i++) issue_request(KIND_PUT, CH_NEWLINE, 11'd0);
            end else if (sel < 63) begin
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++) issue_request(KIND_PUT, CH_TAB, 11'd0);
            end else if (sel < 78) begin
                // Read probes: near the cursor row, anywhere, or past the end.
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: idx = INDEX_W'(cur_row * COLUMNS
                                                      + $urandom_range(0, COLUMNS - 1));
                        5, 6, 7:       idx = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
                        default:       idx = INDEX_W'($urandom_range(0, 2047));
                    endcase
                    issue_request(KIND_READ, CHAR_W'($urandom_range(0, 255)), idx);
                end
            end else if (sel < 88) begin
                // Noise: any kind, any field values.
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    issue_request(t_kind'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                                  INDEX_W'($urandom_range(0, 2047)));
            end else if (sel < 93) begin
                issue_request(KIND_NOP, CHAR_W'($urandom_range(0, 255)),
                              INDEX_W'($urandom_range(0, 2047)));
            end else if (sel < 98) begin
                // Hold off until the block has answered everything.
                wait_until_quiet();
            end else begin
                issue_request(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
                              INDEX_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        model_color = RESET_COLOR;
        cur_row     = 0;
        cur_col     = 0;
        blank_screen_model(RESET_COLOR);

        // Hold reset, then let the power-up blanking sweep finish.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        test_power_up();
        test_put_codes();
        test_tab_wrap();
        test_clear_color();

        write_text_color(8'h00);
        test_random_traffic(100);
        write_text_color(8'hFF);
        test_random_traffic(100);
        write_text_color(COLOR_W'($urandom_range(0, 255)));
        test_random_traffic(100);
        write_text_color(COLOR_W'($urandom_range(0, 255)));
        test_random_traffic(100);

        // Drain, then keep watching for stray results.
        wait_until_quiet();
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_text_console_writer_unit passed");
        end else begin
            $display("tb_text_console_writer_unit failed");
        end
        $finish;
    end

    // Watchdog: far beyond a run where every request scrolls or clears.
    initial begin
        #20_000_000;
        $display("tb_text_console_writer_unit failed");
        $finish;
    end

endmodule
